FILE: hdl/integer_to_radix_digits_defines.svh
// ---------------------------------------------------------------------------
// integer_to_radix_digits assertion macros
// Shared concurrent assertion forms for the radix converter checkers.
// ---------------------------------------------------------------------------
`ifndef INTEGER_TO_RADIX_DIGITS_DEFINES_SVH
`define INTEGER_TO_RADIX_DIGITS_DEFINES_SVH

// same-cycle implication, held off during reset
`define I2RD_ASSERT_IMPLY(lbl, clk, rst_n, a, b) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (a) |-> (b)) \
        else $error("radix converter check failed");

// next-cycle implication, held off during reset
`define I2RD_ASSERT_NEXT(lbl, clk, rst_n, a, b) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (a) |=> (b)) \
        else $error("radix converter check failed");

`endif

FILE: hdl/i2rd_pkg.sv
// ---------------------------------------------------------------------------
// i2rd_pkg
// Types and constants shared by the radix converter modules.
// ---------------------------------------------------------------------------
package i2rd_pkg;

    localparam int VALUE_BITS = 64;
    localparam int IN_W       = 64;
    localparam int BASE_W     = 6;
    localparam int DIGIT_W    = 6;
    localparam int SIGN_W     = 2;
    localparam int CNT_W      = $clog2(VALUE_BITS);

    localparam logic [BASE_W-1:0] BASE_MIN = BASE_W'(2);
    localparam logic [BASE_W-1:0] BASE_MAX = BASE_W'(36);

    typedef enum logic [SIGN_W-1:0] {
        SGN_ZERO = 2'd0,
        SGN_POS  = 2'd1,
        SGN_NEG  = 2'd2
    } sign_t;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_DIV,
        ST_OUT
    } state_t;

    // sequencer to divider
    typedef struct packed {
        logic load;
        logic clear_rem;
        logic step;
    } div_cmd_t;

    // divider to sequencer
    typedef struct packed {
        logic [DIGIT_W-1:0] rem;
        logic               quo_zero;
    } div_stat_t;

endpackage

FILE: hdl/i2rd_divider.sv
// ---------------------------------------------------------------------------
// i2rd_divider
// Restoring divider by a small radix, one quotient bit per step.
// ---------------------------------------------------------------------------
module i2rd_divider
(
    input  logic                               clk,
    input  logic                               rst_n,
    input  i2rd_pkg::div_cmd_t                 cmd,
    input  logic [i2rd_pkg::VALUE_BITS-1:0]    load_value,
    input  logic [i2rd_pkg::BASE_W-1:0]        load_base,
    output i2rd_pkg::div_stat_t                stat
);

    logic [i2rd_pkg::VALUE_BITS-1:0] quo_reg;
    logic [i2rd_pkg::VALUE_BITS-1:0] quo_next;
    logic [i2rd_pkg::DIGIT_W-1:0]    rem_reg;
    logic [i2rd_pkg::DIGIT_W-1:0]    rem_next;
    logic [i2rd_pkg::BASE_W-1:0]     base_reg;
    logic [i2rd_pkg::BASE_W-1:0]     base_next;
    logic [i2rd_pkg::DIGIT_W:0]      trial;
    logic [i2rd_pkg::DIGIT_W:0]      diff;
    logic                            ge;

    always_comb
    begin
        trial = {rem_reg, quo_reg[i2rd_pkg::VALUE_BITS-1]};
        ge    = (trial >= {1'b0, base_reg});
        diff  = trial - {1'b0, base_reg};

        quo_next  = quo_reg;
        rem_next  = rem_reg;
        base_next = base_reg;

        if (cmd.load)
        begin
            quo_next  = load_value;
            rem_next  = '0;
            base_next = load_base;
        end
        else if (cmd.clear_rem)
        begin
            rem_next = '0;
        end
        else if (cmd.step)
        begin
            quo_next = {quo_reg[i2rd_pkg::VALUE_BITS-2:0], ge};
            rem_next = ge ? diff[i2rd_pkg::DIGIT_W-1:0] : trial[i2rd_pkg::DIGIT_W-1:0];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            quo_reg  <= '0;
            rem_reg  <= '0;
            base_reg <= i2rd_pkg::BASE_MIN;
        end
        else
        begin
            quo_reg  <= quo_next;
            rem_reg  <= rem_next;
            base_reg <= base_next;
        end
    end

    assign stat.rem      = rem_reg;
    assign stat.quo_zero = (quo_reg == '0);

endmodule

FILE: hdl/i2rd_ctrl.sv
// ---------------------------------------------------------------------------
// i2rd_ctrl
// Sequencer: takes an item, runs one division per digit, hands out digits.
// ---------------------------------------------------------------------------
module i2rd_ctrl
(
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  in_valid,
    output logic                  in_ready,
    input  logic                  raw_zero,
    input  logic                  raw_neg,
    output logic                  out_valid,
    input  logic                  out_ready,
    output i2rd_pkg::sign_t       sign_out,
    input  i2rd_pkg::div_stat_t   stat,
    output i2rd_pkg::div_cmd_t    cmd
);

    i2rd_pkg::state_t            state_reg;
    i2rd_pkg::state_t            state_next;
    i2rd_pkg::sign_t             sign_reg;
    i2rd_pkg::sign_t             sign_next;
    logic [i2rd_pkg::CNT_W-1:0]  cnt_reg;
    logic [i2rd_pkg::CNT_W-1:0]  cnt_next;
    logic                        in_fire;
    logic                        out_fire;
    logic                        cnt_done;

    assign in_fire  = in_valid && (state_reg == i2rd_pkg::ST_IDLE);
    assign out_fire = out_ready && (state_reg == i2rd_pkg::ST_OUT);
    assign cnt_done = (cnt_reg == i2rd_pkg::CNT_W'(i2rd_pkg::VALUE_BITS - 1));

    // next state
    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            i2rd_pkg::ST_IDLE:
            begin
                if (in_valid)
                begin
                    state_next = raw_zero ? i2rd_pkg::ST_OUT : i2rd_pkg::ST_DIV;
                end
            end
            i2rd_pkg::ST_DIV:
            begin
                if (cnt_done)
                begin
                    state_next = i2rd_pkg::ST_OUT;
                end
            end
            i2rd_pkg::ST_OUT:
            begin
                if (out_ready)
                begin
                    state_next = stat.quo_zero ? i2rd_pkg::ST_IDLE : i2rd_pkg::ST_DIV;
                end
            end
            default:
            begin
                state_next = i2rd_pkg::ST_IDLE;
            end
        endcase
    end

    // outputs
    always_comb
    begin
        in_ready      = 1'b0;
        out_valid     = 1'b0;
        cmd.load      = 1'b0;
        cmd.clear_rem = 1'b0;
        cmd.step      = 1'b0;
        case (state_reg)
            i2rd_pkg::ST_IDLE:
            begin
                in_ready = 1'b1;
                cmd.load = in_valid;
            end
            i2rd_pkg::ST_DIV:
            begin
                cmd.step = 1'b1;
            end
            i2rd_pkg::ST_OUT:
            begin
                out_valid     = 1'b1;
                cmd.clear_rem = out_ready && !stat.quo_zero;
            end
            default:
            begin
                in_ready = 1'b0;
            end
        endcase
    end

    always_comb
    begin
        sign_next = sign_reg;
        cnt_next  = cnt_reg;
        if (in_fire)
        begin
            sign_next = raw_zero ? i2rd_pkg::SGN_ZERO :
                        (raw_neg ? i2rd_pkg::SGN_NEG : i2rd_pkg::SGN_POS);
            cnt_next  = '0;
        end
        else if (out_fire)
        begin
            cnt_next = '0;
        end
        else if (state_reg == i2rd_pkg::ST_DIV)
        begin
            cnt_next = cnt_reg + 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= i2rd_pkg::ST_IDLE;
            sign_reg  <= i2rd_pkg::SGN_ZERO;
            cnt_reg   <= '0;
        end
        else
        begin
            state_reg <= state_next;
            sign_reg  <= sign_next;
            cnt_reg   <= cnt_next;
        end
    end

    assign sign_out = sign_reg;

endmodule

FILE: hdl/integer_to_radix_digits.sv
// ---------------------------------------------------------------------------
// integer_to_radix_digits
// Binary to radix 2..36 conversion by repeated division, digits LS first.
// ---------------------------------------------------------------------------
// One item is taken when idle; in_ready stays low until its last digit is
// taken. Each digit takes a full pass of the shared bit-serial divider and
// then its output handshake; zero skips the divider and gives its single
// digit. Digits come out least significant first, each with the sign code
// of the whole number, and last is set on the most significant digit.
module integer_to_radix_digits
(
    input  logic                              clk,
    input  logic                              rst_n,
    input  logic                              in_valid,
    output logic                              in_ready,
    input  logic [i2rd_pkg::IN_W-1:0]         value,
    input  logic                              is_signed,
    input  logic [i2rd_pkg::BASE_W-1:0]       base,
    output logic                              out_valid,
    input  logic                              out_ready,
    output logic [i2rd_pkg::DIGIT_W-1:0]      digit,
    output logic [i2rd_pkg::SIGN_W-1:0]       sign,
    output logic                              last
);

    logic [i2rd_pkg::VALUE_BITS-1:0] raw;
    logic [i2rd_pkg::VALUE_BITS-1:0] mag;
    logic [i2rd_pkg::BASE_W-1:0]     base_clamped;
    logic                            raw_neg;
    logic                            raw_zero;
    i2rd_pkg::div_cmd_t              cmd;
    i2rd_pkg::div_stat_t             stat;
    i2rd_pkg::sign_t                 sign_code;

    assign raw      = value[i2rd_pkg::VALUE_BITS-1:0];
    assign raw_neg  = is_signed && raw[i2rd_pkg::VALUE_BITS-1];
    assign raw_zero = (raw == '0);
    // most negative value negates to itself, read unsigned it is the magnitude
    assign mag      = raw_neg ? (~raw + 1'b1) : raw;

    always_comb
    begin
        if (base < i2rd_pkg::BASE_MIN)
        begin
            base_clamped = i2rd_pkg::BASE_MIN;
        end
        else if (base > i2rd_pkg::BASE_MAX)
        begin
            base_clamped = i2rd_pkg::BASE_MAX;
        end
        else
        begin
            base_clamped = base;
        end
    end

    i2rd_ctrl u_ctrl
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_ready  (in_ready),
        .raw_zero  (raw_zero),
        .raw_neg   (raw_neg),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .sign_out  (sign_code),
        .stat      (stat),
        .cmd       (cmd)
    );

    i2rd_divider u_div
    (
        .clk        (clk),
        .rst_n      (rst_n),
        .cmd        (cmd),
        .load_value (mag),
        .load_base  (base_clamped),
        .stat       (stat)
    );

    assign digit = stat.rem;
    assign sign  = sign_code;
    assign last  = stat.quo_zero;

endmodule

FILE: hdl/i2rd_checker.sv
// ---------------------------------------------------------------------------
// i2rd_checker
// Port-level checks for the radix converter, bound to the top level.
// ---------------------------------------------------------------------------
`include "integer_to_radix_digits_defines.svh"

module i2rd_checker
(
    input  logic                              clk,
    input  logic                              rst_n,
    input  logic                              in_valid,
    input  logic                              in_ready,
    input  logic [i2rd_pkg::IN_W-1:0]         value,
    input  logic                              is_signed,
    input  logic [i2rd_pkg::BASE_W-1:0]       base,
    input  logic                              out_valid,
    input  logic                              out_ready,
    input  logic [i2rd_pkg::DIGIT_W-1:0]      digit,
    input  logic [i2rd_pkg::SIGN_W-1:0]       sign,
    input  logic                              last
);

    logic zero_item;
    logic busy;
    logic [i2rd_pkg::DIGIT_W+i2rd_pkg::SIGN_W:0] out_bus;

    assign zero_item = (sign == i2rd_pkg::SGN_ZERO);
    assign busy      = in_valid && in_ready && (value != '0 || is_signed || base != '0);
    assign out_bus   = {digit, sign, last};

    // a held item keeps its fields
    `I2RD_ASSERT_NEXT(a_out_hold, clk, rst_n, out_valid && !out_ready, out_valid && $stable(out_bus))
    // no new item while a digit is on offer
    `I2RD_ASSERT_IMPLY(a_no_overlap, clk, rst_n, out_valid, !in_ready)
    // zero comes out as a single digit 0
    `I2RD_ASSERT_IMPLY(a_zero_item, clk, rst_n, out_valid && zero_item, digit == '0 && last)
    // digits stay below the largest radix and the sign code is defined
    `I2RD_ASSERT_IMPLY(a_digit_range, clk, rst_n, out_valid || busy, digit <= 6'd35 && sign <= i2rd_pkg::SGN_NEG)

endmodule

bind integer_to_radix_digits i2rd_checker u_i2rd_checker (.*);

FILE: tb/integer_to_radix_digits_tb.sv
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// integer_to_radix_digits_tb
// Feeds integers with a sign flag and a radix through the valid/ready input
// and checks every digit that comes out, least significant first, against
// a repeated-division model kept here. Directed corner items come first,
// then random ones, under three idling schemes on the two channels.
// ---------------------------------------------------------------------------
module integer_to_radix_digits_tb;

    localparam int RANDOM_ITEMS = 189;
    localparam int PHASE_ITEMS  = 70;
    localparam int STALL_LIMIT  = 4000;
    localparam int DRAIN_CYCLES = 200;

    typedef struct {
        logic [i2rd_pkg::IN_W-1:0]   value;
        logic                        is_signed;
        logic [i2rd_pkg::BASE_W-1:0] base;
    } conv_item_t;

    typedef struct {
        logic [i2rd_pkg::DIGIT_W-1:0] digit;
        i2rd_pkg::sign_t              sgn;
        logic                         last;
    } digit_rec_t;

    logic                           clk       = 1'b0;
    logic                           rst_n     = 1'b0;
    logic                           in_valid  = 1'b0;
    logic                           in_ready;
    logic [i2rd_pkg::IN_W-1:0]      value     = '0;
    logic                           is_signed = 1'b0;
    logic [i2rd_pkg::BASE_W-1:0]    base      = '0;
    logic                           out_valid;
    logic                           out_ready = 1'b0;
    logic [i2rd_pkg::DIGIT_W-1:0]   digit;
    logic [i2rd_pkg::SIGN_W-1:0]    sign;
    logic                           last;

    conv_item_t items_to_send[$];
    digit_rec_t expected_digits[$];
    int         mismatches   = 0;
    int         items_taken  = 0;
    int         quiet_cycles = 0;

    integer_to_radix_digits dut
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_ready  (in_ready),
        .value     (value),
        .is_signed (is_signed),
        .base      (base),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .digit     (digit),
        .sign      (sign),
        .last      (last)
    );

    always
    begin
        #4 clk = 1'b1;
        #4 clk = 1'b0;
    end

    // percentage of idle cycles for each side, by how far the run has got
    function automatic int idle_share(input bit for_sender);
        if (items_taken < PHASE_ITEMS)
            return for_sender ? 20 : 45;
        else if (items_taken < 2 * PHASE_ITEMS)
            return for_sender ? 45 : 20;
        else
            return 0;
    endfunction

    task automatic predict_radix_digits(input conv_item_t it);
        logic [i2rd_pkg::IN_W-1:0] width_mask;
        logic [i2rd_pkg::IN_W-1:0] raw;
        logic [i2rd_pkg::IN_W-1:0] mag;
        logic [i2rd_pkg::IN_W-1:0] radix;
        i2rd_pkg::sign_t           sgn;
        digit_rec_t                rec;
        width_mask = {i2rd_pkg::IN_W{1'b1}} >> (i2rd_pkg::IN_W - i2rd_pkg::VALUE_BITS);
        raw = it.value & width_mask;
        if (it.base < i2rd_pkg::BASE_MIN)
            radix = i2rd_pkg::IN_W'(i2rd_pkg::BASE_MIN);
        else if (it.base > i2rd_pkg::BASE_MAX)
            radix = i2rd_pkg::IN_W'(i2rd_pkg::BASE_MAX);
        else
            radix = i2rd_pkg::IN_W'(it.base);
        if (raw == '0)
        begin
            rec.digit = '0;
            rec.sgn   = i2rd_pkg::SGN_ZERO;
            rec.last  = 1'b1;
            expected_digits.push_back(rec);
        end
        else
        begin
            if (it.is_signed && raw[i2rd_pkg::VALUE_BITS-1])
            begin
                sgn = i2rd_pkg::SGN_NEG;
                mag = (~raw + 1'b1) & width_mask;
            end
            else
            begin
                sgn = i2rd_pkg::SGN_POS;
                mag = raw;
            end
            while (mag != '0)
            begin
                rec.digit = i2rd_pkg::DIGIT_W'(mag % radix);
                mag       = mag / radix;
                rec.sgn   = sgn;
                rec.last  = (mag == '0);
                expected_digits.push_back(rec);
            end
        end
    endtask

    task automatic flag_mismatch(input string what);
        $display("%0t ns: %s", $time, what);
        mismatches++;
    endtask

    function automatic void add_item(input logic [i2rd_pkg::IN_W-1:0] v, input logic s,
                                     input logic [i2rd_pkg::BASE_W-1:0] b);
        conv_item_t it;
        it.value     = v;
        it.is_signed = s;
        it.base      = b;
        items_to_send.push_back(it);
    endfunction

    // bit widths are drawn uniformly so that small and large magnitudes both occur
    function automatic conv_item_t random_item();
        conv_item_t                it;
        logic [i2rd_pkg::IN_W-1:0] bits;
        int unsigned               width;
        bits  = {$urandom, $urandom};
        width = $urandom_range(0, i2rd_pkg::IN_W);
        it.value     = (width == 0) ? '0 : bits >> (i2rd_pkg::IN_W - width);
        it.is_signed = 1'($urandom_range(0, 1));
        if (it.is_signed && $urandom_range(0, 1) == 1)
            it.value = -it.value;
        if ($urandom_range(0, 9) == 0)
            it.base = i2rd_pkg::BASE_W'($urandom_range(0, 63));
        else
            it.base = i2rd_pkg::BASE_W'($urandom_range(2, 36));
        return it;
    endfunction

    // driver
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid  <= 1'b0;
            value     <= '0;
            is_signed <= 1'b0;
            base      <= '0;
        end
        else if (!in_valid || in_ready)
        begin
            if (items_to_send.size() != 0 && $urandom_range(0, 99) >= idle_share(1'b1))
            begin
                in_valid  <= 1'b1;
                value     <= items_to_send[0].value;
                is_signed <= items_to_send[0].is_signed;
                base      <= items_to_send[0].base;
                void'(items_to_send.pop_front());
            end
            else
            begin
                in_valid <= 1'b0;
            end
        end
    end

    // monitor
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_ready   <= 1'b0;
            items_taken <= 0;
        end
        else
        begin
            out_ready <= ($urandom_range(0, 99) >= idle_share(1'b0));
            if (in_valid && in_ready)
            begin
                predict_radix_digits('{value, is_signed, base});
                items_taken <= items_taken + 1;
            end
            if (out_valid && out_ready)
            begin
                if (expected_digits.size() == 0)
                begin
                    flag_mismatch($sformatf("digit %0d sign %0d last %0b with none expected",
                                            digit, sign, last));
                end
                else
                begin
                    if (digit !== expected_digits[0].digit)
                        flag_mismatch($sformatf("digit: got %0d, want %0d",
                                                digit, expected_digits[0].digit));
                    if (sign !== expected_digits[0].sgn)
                        flag_mismatch($sformatf("sign: got %0d, want %s",
                                                sign, expected_digits[0].sgn.name()));
                    if (last !== expected_digits[0].last)
                        flag_mismatch($sformatf("last: got %0b, want %0b",
                                                last, expected_digits[0].last));
                    void'(expected_digits.pop_front());
                end
            end
        end
    end

    // watchdog on cycles with no item moving on either side
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if ((in_valid && in_ready) || (out_valid && out_ready))
            begin
                quiet_cycles <= 0;
            end
            else if (quiet_cycles >= STALL_LIMIT - 1)
            begin
                $display("integer_to_radix_digits_tb: done, errors");
                $finish;
            end
            else
            begin
                quiet_cycles <= quiet_cycles + 1;
            end
        end
    end

    initial
    begin
        add_item('0, 1'b0, 6'd10);
        add_item('0, 1'b1, 6'd36);
        add_item(64'd1, 1'b0, 6'd2);
        add_item('1, 1'b0, 6'd2);
        add_item('1, 1'b0, 6'd36);
        add_item('1, 1'b1, 6'd10);
        add_item(64'h8000_0000_0000_0000, 1'b1, 6'd2);
        add_item(64'h8000_0000_0000_0000, 1'b1, 6'd36);
        add_item(64'h8000_0000_0000_0000, 1'b0, 6'd10);
        add_item(64'h7fff_ffff_ffff_ffff, 1'b1, 6'd16);
        add_item(64'd35, 1'b0, 6'd36);
        add_item(64'd36, 1'b0, 6'd36);
        add_item(-64'd255, 1'b1, 6'd16);
        add_item(64'd255, 1'b1, 6'd16);
        // radix out of range on both sides
        add_item(64'd100, 1'b0, 6'd0);
        add_item(64'd100, 1'b1, 6'd1);
        add_item(64'd100, 1'b0, 6'd37);
        add_item(64'd100, 1'b0, 6'd63);
        add_item(64'd10000000000000000000, 1'b0, 6'd10);
        add_item('1, 1'b0, 6'd3);
        add_item(64'h0123_4567_89ab_cdef, 1'b0, 6'd16);
        repeat (RANDOM_ITEMS)
            items_to_send.push_back(random_item());

        repeat (11) @(posedge clk);
        rst_n <= 1'b1;

        while (items_to_send.size() != 0 || in_valid)
            @(posedge clk);
        while (expected_digits.size() != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);

        if (mismatches == 0)
            $display("integer_to_radix_digits_tb: done, clean");
        else
            $display("integer_to_radix_digits_tb: done, errors");
        $finish;
    end

endmodule
